// ===== src/icph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_pkg
// Shared types, register codes and a ones-complement fold helper for the
// internet checksum block with IPv4 pseudo header.
// ----------------------------------------------------------------------------
package icph_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned WideW   = 19;

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_CSUM   = 2'd1,
    MODE_PSEUDO = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MODE  = 2'd0,
    CFG_SRC   = 2'd1,
    CFG_DST   = 2'd2,
    CFG_PROTO = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             advance;
    logic             present;
    logic             last;
    logic [ByteW-1:0] data;
  } step_t;

  typedef struct packed {
    logic [WordW-1:0] sum;
    logic             overflow;
  } res_t;

  function automatic logic [WordW-1:0] oc_fold(input logic [WideW-1:0] s);
    logic [WordW:0] t;
    logic [WordW:0] r;
    t = {1'b0, s[WordW-1:0]} + {14'd0, s[WideW-1:WordW]};
    r = {1'b0, t[WordW-1:0]} + {16'd0, t[WordW]};
    return r[WordW-1:0];
  endfunction

endpackage

// ===== src/icph_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_accum
// Message state: pairs bytes into big-endian words, keeps the end-around
// carry sum and byte count, and forms the final sum on the last request.
// ----------------------------------------------------------------------------
module icph_accum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  icph_pkg::step_t                step_i,
  input  logic                           pseudo_en_i,
  input  logic [icph_pkg::WordW-1:0]     ph_sum_i,
  output icph_pkg::res_t                 res_o
);

  logic [icph_pkg::WordW-1:0] sum_q, sum_d;
  logic [icph_pkg::ByteW-1:0] held_q, held_d;
  logic                       odd_q, odd_d;
  logic [icph_pkg::WordW-1:0] cnt_q, cnt_d;
  logic                       ovf_q, ovf_d;

  logic [icph_pkg::WordW-1:0] word;
  logic [icph_pkg::WordW-1:0] cnt_next;
  logic                       ovf_next;
  logic [icph_pkg::WordW-1:0] ph_term;
  logic [icph_pkg::WordW-1:0] cnt_term;
  logic [icph_pkg::WideW-1:0] pair_wide;
  logic [icph_pkg::WideW-1:0] final_wide;

  always_comb begin
    if (odd_q) begin
      word = {held_q, step_i.present ? step_i.data : 8'd0};
    end else if (step_i.present) begin
      word = {step_i.data, 8'd0};
    end else begin
      word = '0;
    end
    cnt_next  = cnt_q + {15'd0, step_i.present};
    ovf_next  = ovf_q | (step_i.present & (cnt_q == 16'hFFFF));
    ph_term   = pseudo_en_i ? ph_sum_i : '0;
    cnt_term  = pseudo_en_i ? cnt_next : '0;
    pair_wide = {3'd0, sum_q} + {3'd0, word};
    final_wide = {3'd0, sum_q} + {3'd0, word} + {3'd0, ph_term} + {3'd0, cnt_term};
    res_o.sum      = icph_pkg::oc_fold(final_wide);
    res_o.overflow = ovf_next;

    sum_d  = sum_q;
    held_d = held_q;
    odd_d  = odd_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    if (step_i.advance) begin
      if (step_i.last) begin
        sum_d  = '0;
        held_d = '0;
        odd_d  = 1'b0;
        cnt_d  = '0;
        ovf_d  = 1'b0;
      end else begin
        cnt_d = cnt_next;
        ovf_d = ovf_next;
        if (step_i.present) begin
          if (odd_q) begin
            sum_d  = icph_pkg::oc_fold(pair_wide);
            held_d = '0;
            odd_d  = 1'b0;
          end else begin
            held_d = step_i.data;
            odd_d  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      held_q <= '0;
      odd_q  <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      held_q <= held_d;
      odd_q  <= odd_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ===== src/internet_checksum_pseudo_header.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header
// Ones-complement internet checksum over a byte stream, with optional
// IPv4 pseudo header.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (data_valid_i / data_ready_o) carries one message byte per
//   request with byte_present_i and is_last_i. A request with is_last_i high
//   closes the message and yields one result on the output channel
//   (result_valid_o / result_ready_i); other requests yield none.
//   Throughput is one request per cycle unless a last request waits for the
//   result register. A last request held in the input register feeds the
//   accumulator adder, which loads the result register once it is free.
//   When the receiver stalls, the result register holds; non-last requests
//   keep flowing, and a further last request waits in the input register,
//   which then drops data_ready_o until the result is taken.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is to be written by the user
//   while idle; the block does not enforce it. Reset clears the message state,
//   empties both registers and sets complemented checksum mode, zero addresses and protocol.
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [icph_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          data_valid_i,
  output logic                          data_ready_o,
  input  logic [icph_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          byte_present_i,
  input  logic                          is_last_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic [icph_pkg::WordW-1:0]    checksum_value_o,
  output logic                          is_valid_o,
  output logic                          length_overflow_o
);

  logic [1:0]                 mode_q;
  logic [icph_pkg::AddrW-1:0] src_q;
  logic [icph_pkg::AddrW-1:0] dst_q;
  logic [icph_pkg::ByteW-1:0] proto_q;
  logic [icph_pkg::WordW-1:0] ph_q, ph_d;

  logic                       in_vld_q;
  logic [icph_pkg::ByteW-1:0] in_byte_q;
  logic                       in_present_q;
  logic                       in_last_q;

  logic                       out_vld_q;
  logic [icph_pkg::WordW-1:0] out_sum_q;
  logic                       out_valid_q;
  logic                       out_ovf_q;

  logic                       out_free;
  logic                       in_fire;
  logic                       in_take;
  logic                       out_load;
  logic [icph_pkg::WordW-1:0] csum;
  icph_pkg::step_t            step;
  icph_pkg::res_t             res;

  assign out_free     = !out_vld_q || result_ready_i;
  assign in_fire      = in_vld_q && (!in_last_q || out_free);
  assign data_ready_o = !in_vld_q || in_fire;
  assign in_take      = data_valid_i && data_ready_o;
  assign out_load     = in_fire && in_last_q;

  assign step.advance = in_fire;
  assign step.present = in_present_q;
  assign step.last    = in_last_q;
  assign step.data    = in_byte_q;

  assign ph_d = icph_pkg::oc_fold({3'd0, src_q[31:16]} + {3'd0, src_q[15:0]}
                                + {3'd0, dst_q[31:16]} + {3'd0, dst_q[15:0]}
                                + {11'd0, proto_q});

  assign csum = ~res.sum;

  icph_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pseudo_en_i (mode_q == icph_pkg::MODE_PSEUDO),
    .ph_sum_i    (ph_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= icph_pkg::MODE_CSUM;
      src_q   <= '0;
      dst_q   <= '0;
      proto_q <= '0;
      ph_q    <= '0;
    end else begin
      ph_q <= ph_d;
      if (cfg_we_i) begin
        unique case (icph_pkg::cfg_idx_e'(cfg_idx_i))
          icph_pkg::CFG_MODE:  mode_q  <= cfg_data_i[1:0];
          icph_pkg::CFG_SRC:   src_q   <= cfg_data_i;
          icph_pkg::CFG_DST:   dst_q   <= cfg_data_i;
          icph_pkg::CFG_PROTO: proto_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (data_ready_o) begin
        in_vld_q <= data_valid_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (result_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q    <= data_byte_i;
      in_present_q <= byte_present_i;
      in_last_q    <= is_last_i;
    end
    if (out_load) begin
      out_sum_q   <= (mode_q == icph_pkg::MODE_RAW) ? res.sum : csum;
      out_valid_q <= (csum == '0);
      out_ovf_q   <= res.overflow;
    end
  end

  assign result_valid_o    = out_vld_q;
  assign checksum_value_o  = out_sum_q;
  assign is_valid_o        = out_valid_q;
  assign length_overflow_o = out_ovf_q;

endmodule
